/* design/swlg_pkg.sv */
`default_nettype none

package swlg_pkg;

  // Field widths
  localparam int OP_W      = 1;
  localparam int STEP_W    = 11;
  localparam int PIXEL_W   = 16;
  localparam int GRAY_W    = 8;
  localparam int INDEX_W   = 12;
  localparam int SUM_W     = 14;

  // Register widths
  localparam int SLOPE_W   = 24;
  localparam int OFFSET_W  = 16;
  localparam int CENTER_W  = 21;
  localparam int WIDTH_W   = 21;
  localparam int SLICES_W  = 13;

  // Configuration port
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SLICES  = 3'd5;

  // Operation codes
  localparam logic OP_TURN  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Largest slice count handled
  localparam int MAX_SLICES = 4096;

  // Fixed point: 16 fraction bits
  localparam int FRAC_W = 16;

  // Reset values of the registers
  localparam logic [SLOPE_W-1:0]         SLOPE_RESET  = 24'd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 16'sd0;
  localparam logic signed [CENTER_W-1:0] CENTER_RESET = 21'sd40;
  localparam logic [WIDTH_W-1:0]         WIDTH_RESET  = 21'd400;
  localparam logic [SLICES_W-1:0]        SLICES_RESET = 13'd1;

endpackage

`default_nettype wire

/* design/swlg_if.sv */
`default_nettype none

// Item channel into the block
interface swlg_item_if;
  logic                                       valid;
  logic                                       ready;
  logic [swlg_pkg::OP_W-1:0]                  operation;
  logic signed [swlg_pkg::STEP_W-1:0]         turn_step;
  logic signed [swlg_pkg::PIXEL_W-1:0]        pixel_value;

  modport source (output valid, operation, turn_step, pixel_value, input ready);
  modport sink   (input valid, operation, turn_step, pixel_value, output ready);
endinterface

// Result channel out of the block
interface swlg_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [swlg_pkg::GRAY_W-1:0]          gray_level;
  logic [swlg_pkg::INDEX_W-1:0]         slice_index;

  modport source (output valid, gray_level, slice_index, input ready);
  modport sink   (input valid, gray_level, slice_index, output ready);
endinterface

`default_nettype wire

/* design/slice_window_level_to_gray_top.sv */
`default_nettype none

// Slice paging and window/level gray mapping. A turn transaction (operation 0)
// adds turn_step to the paging sum, clamps it around the middle slice and
// returns the slice index through the turn state, with gray_level 0. A
// pixel transaction (operation 1) rescales pixel_value by slope and offset,
// maps it through the window and returns gray_level and the current slice
// index. A pixel passes in order through the acceptance, a multiply step,
// a truncation step, a set-up step, a serial restoring divider by
// window_width that makes 16 quotient bits (one quotient bit per cycle) and
// the gray steps. When the distance from the window center reaches the
// window width the divider is skipped. One item is in work at a time; the
// result register lets the next item be accepted while a finished result
// still waits to be taken, and an item that finishes while that result is
// still held waits in its last state until the result is taken. The user
// must write registers only while the block is idle; the block itself does
// not enforce this. window_width 0 acts as 1, slice_count 0 as 1.

module slice_window_level_to_gray_top (
  input  wire                                   clk,
  input  wire                                   rst,
  swlg_item_if.sink                             items,
  swlg_result_if.source                         results,
  input  wire                                   cfg_we,
  input  wire [swlg_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire [swlg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TURN  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_PREP  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_GRAY1 = 3'd6;
  localparam logic [2:0] ST_GRAY2 = 3'd7;

  localparam int PROD_W = 41;
  localparam int CT_W   = 25;
  localparam int D_W    = 26;
  localparam int SW     = 15;
  localparam int QUO_W  = swlg_pkg::FRAC_W;
  localparam int G_W    = swlg_pkg::FRAC_W + 1;
  localparam logic [G_W-1:0] G_FULL = G_W'(1 << swlg_pkg::FRAC_W);
  localparam logic [G_W-1:0] G_HALF = G_W'(1 << (swlg_pkg::FRAC_W - 1));

  // Configuration registers
  logic [swlg_pkg::SLOPE_W-1:0]          slope;
  logic signed [swlg_pkg::OFFSET_W-1:0]  offset;
  logic signed [swlg_pkg::CENTER_W-1:0]  center;
  logic [swlg_pkg::WIDTH_W-1:0]          width;
  logic                                  invert;
  logic [swlg_pkg::SLICES_W-1:0]         slice_count;

  // State and work registers
  logic [2:0]                            state;
  logic signed [swlg_pkg::SUM_W-1:0]     paging_sum;
  logic signed [swlg_pkg::STEP_W-1:0]    step_q;
  logic signed [swlg_pkg::PIXEL_W-1:0]   px_q;
  logic signed [PROD_W-1:0]              prod;
  logic signed [CT_W-1:0]                ct;
  logic                                  neg;
  logic [swlg_pkg::WIDTH_W-1:0]          rem;
  logic [QUO_W-1:0]                      quo;
  logic [3:0]                            cnt;
  logic [G_W-1:0]                        g_reg;

  // Result register
  logic                                  res_valid;
  logic [swlg_pkg::GRAY_W-1:0]           res_gray;
  logic [swlg_pkg::INDEX_W-1:0]          res_index;

  logic res_free;
  assign res_free = !res_valid || results.ready;

  // Result register loads when a turn or a gray finishes into a free slot
  logic res_load;
  assign res_load = ((state == ST_TURN) || (state == ST_GRAY2)) && res_free;

  assign items.ready         = (state == ST_IDLE);
  assign results.valid       = res_valid;
  assign results.gray_level  = res_gray;
  assign results.slice_index = res_index;

  // Effective slice count and the clamp limits derived from it
  logic [swlg_pkg::SLICES_W-1:0] z;
  logic signed [SW-1:0] h_s, c_s, zm1_s;
  always_comb begin
    if (slice_count == '0) begin
      z = swlg_pkg::SLICES_W'(1);
    end else if (slice_count > swlg_pkg::SLICES_W'(swlg_pkg::MAX_SLICES)) begin
      z = swlg_pkg::SLICES_W'(swlg_pkg::MAX_SLICES);
    end else begin
      z = slice_count;
    end
    h_s   = signed'(SW'(z >> 1));
    c_s   = z[0] ? SW'(2) : SW'(1);
    zm1_s = signed'(SW'(z)) - SW'(1);
  end

  // Turn: add step, clamp sum, derive index
  logic signed [SW-1:0] s_raw, s_clmp, t_idx, s_new, idx_new;
  always_comb begin
    s_raw = SW'(paging_sum) + SW'(step_q);
    if (s_raw < -h_s - c_s) begin
      s_clmp = -h_s - c_s;
    end else if (s_raw > h_s + c_s) begin
      s_clmp = h_s + c_s;
    end else begin
      s_clmp = s_raw;
    end
    t_idx = h_s + s_clmp;
    if (t_idx < 0) begin
      idx_new = '0;
      s_new   = -h_s;
    end else if (t_idx > zm1_s) begin
      idx_new = zm1_s;
      s_new   = h_s + c_s - SW'(2);
    end else begin
      idx_new = t_idx;
      s_new   = s_clmp;
    end
  end

  // Pixel: report the current index clamped to the volume
  logic signed [SW-1:0] p_raw, p_idx;
  always_comb begin
    p_raw = h_s + SW'(paging_sum);
    if (p_raw < 0) begin
      p_idx = '0;
    end else if (p_raw > zm1_s) begin
      p_idx = zm1_s;
    end else begin
      p_idx = p_raw;
    end
  end

  // Rescale: truncate (prod + offset) toward zero
  logic signed [PROD_W-1:0] psum;
  logic signed [CT_W-1:0]   ct_c;
  always_comb begin
    psum = prod + (PROD_W'(offset) <<< swlg_pkg::FRAC_W);
    ct_c = CT_W'(psum >>> swlg_pkg::FRAC_W) +
           ((psum[PROD_W-1] && (psum[swlg_pkg::FRAC_W-1:0] != '0)) ? CT_W'(1) : CT_W'(0));
  end

  // Divider set-up: distance from the centre as sign and magnitude
  logic [swlg_pkg::WIDTH_W-1:0] w_eff;
  logic signed [D_W-1:0]        d;
  logic [D_W-1:0]               mag;
  logic                         ovf;
  always_comb begin
    w_eff = (width == '0) ? swlg_pkg::WIDTH_W'(1) : width;
    d     = D_W'(ct) - D_W'(center);
    mag   = d[D_W-1] ? D_W'(-d) : D_W'(d);
    ovf   = mag >= D_W'(w_eff);
  end

  // One restoring divide step
  logic [swlg_pkg::WIDTH_W:0]   rem_sh;
  logic [swlg_pkg::WIDTH_W+1:0] diff;
  logic                         ge;
  always_comb begin
    rem_sh = {rem, 1'b0};
    diff   = {1'b0, rem_sh} - {2'b0, w_eff};
    ge     = !diff[swlg_pkg::WIDTH_W+1];
  end

  // Gray: signed quotient, offset to mid-scale, clamp, invert
  logic signed [G_W:0] q_s, gq;
  logic [G_W-1:0]      g_c;
  always_comb begin
    q_s = neg ? -signed'({2'b0, quo}) : signed'({2'b0, quo});
    gq  = q_s + signed'({1'b0, G_HALF});
    if (gq < 0) begin
      g_c = '0;
    end else if (gq > signed'({1'b0, G_FULL})) begin
      g_c = G_FULL;
    end else begin
      g_c = gq[G_W-1:0];
    end
    if (invert) begin
      g_c = G_FULL - g_c;
    end
  end

  // Scale to 0..255 with rounding
  logic [24:0] gm;
  always_comb begin
    gm = ({g_reg, 8'b0} - {8'b0, g_reg}) + 25'(G_HALF);
  end

  // Registers, sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      res_valid   <= 1'b0;
      paging_sum  <= '0;
      slope       <= swlg_pkg::SLOPE_RESET;
      offset      <= swlg_pkg::OFFSET_RESET;
      center      <= swlg_pkg::CENTER_RESET;
      width       <= swlg_pkg::WIDTH_RESET;
      invert      <= 1'b0;
      slice_count <= swlg_pkg::SLICES_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swlg_pkg::REG_SLOPE:  slope       <= cfg_data[swlg_pkg::SLOPE_W-1:0];
          swlg_pkg::REG_OFFSET: offset      <= signed'(cfg_data[swlg_pkg::OFFSET_W-1:0]);
          swlg_pkg::REG_CENTER: center      <= signed'(cfg_data[swlg_pkg::CENTER_W-1:0]);
          swlg_pkg::REG_WIDTH:  width       <= cfg_data[swlg_pkg::WIDTH_W-1:0];
          swlg_pkg::REG_INVERT: invert      <= cfg_data[0];
          swlg_pkg::REG_SLICES: slice_count <= cfg_data[swlg_pkg::SLICES_W-1:0];
          default: ;
        endcase
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (items.valid) begin
            step_q <= items.turn_step;
            px_q   <= items.pixel_value;
            state  <= (items.operation == swlg_pkg::OP_PIXEL) ? ST_MUL : ST_TURN;
          end
        end
        ST_TURN: begin
          if (res_free) begin
            paging_sum <= swlg_pkg::SUM_W'(s_new);
            res_gray   <= '0;
            res_index  <= swlg_pkg::INDEX_W'(idx_new);
            state      <= ST_IDLE;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(px_q) * signed'(PROD_W'({1'b0, slope}));
          state <= ST_TRUNC;
        end
        ST_TRUNC: begin
          ct    <= ct_c;
          state <= ST_PREP;
        end
        ST_PREP: begin
          neg <= d[D_W-1];
          rem <= mag[swlg_pkg::WIDTH_W-1:0];
          quo <= ovf ? '1 : '0;
          cnt <= 4'(QUO_W - 1);
          state <= ovf ? ST_GRAY1 : ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? diff[swlg_pkg::WIDTH_W-1:0] : rem_sh[swlg_pkg::WIDTH_W-1:0];
          quo <= {quo[QUO_W-2:0], ge};
          cnt <= cnt - 4'd1;
          if (cnt == '0) begin
            state <= ST_GRAY1;
          end
        end
        ST_GRAY1: begin
          g_reg <= g_c;
          state <= ST_GRAY2;
        end
        ST_GRAY2: begin
          if (res_free) begin
            res_gray  <= gm[23:16];
            res_index <= swlg_pkg::INDEX_W'(p_idx);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
